>>> src/mart_pkg.sv
// ----------------------------------------------------------------------------
// mart_pkg: shared types and constants of the moving average band threshold
// Register indexes, field widths, reset values, decision codes and the
// controller-to-datapath command bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package mart_pkg;

  // Default parameter values for the top level.
  localparam int unsigned MART_MAX_WINDOW  = 16;
  localparam int unsigned MART_SAMPLE_BITS = 32;

  // Fixed field widths.
  localparam int unsigned WW_W      = 5;   // window_width register
  localparam int unsigned TOL_W     = 16;  // tolerance register, Q0.16
  localparam int unsigned FRAC_W    = 16;  // fraction bits of the Q16.16 format
  localparam int unsigned SUM_OUT_W = 36;  // window_sum output field
  localparam int unsigned DEC_W     = 2;   // decision output field
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE    = 1'd1;

  // Register reset values.
  localparam logic [WW_W-1:0]  WINDOW_WIDTH_RST = 5'd5;
  localparam logic [TOL_W-1:0] TOLERANCE_RST    = 16'd3277;

  typedef enum logic [DEC_W-1:0] {
    DEC_HOLD = 2'd0,
    DEC_SELL = 2'd1,
    DEC_BUY  = 2'd2
  } decision_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // latch the sample and read the ring slot it replaces
    logic update;  // write the ring, update sum, fill count and pointer
    logic mul;     // form sum * tolerance
    logic result;  // compare and load the output register
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic result_due;  // the window is full after this sample
  } ctl_status_t;

endpackage

`default_nettype wire

>>> src/mart_ctrl.sv
// ----------------------------------------------------------------------------
// mart_ctrl: sequencing controller
// One-hot state machine that walks one sample through read, update, multiply
// and compare, and owns the input ready and the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module mart_ctrl
  import mart_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  input  wire ctl_status_t status_i,
  output ctl_cmd_t         cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_CMP  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   slot_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i & in_ready_o;
  assign slot_free   = ~out_valid_q | out_ready_i;

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = accept;
    cmd_o.update = (state_q == ST_READ);
    cmd_o.mul    = (state_q == ST_MUL);
    cmd_o.result = (state_q == ST_CMP) & slot_free;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_READ;
      end
      ST_READ: begin
        state_d = status_i.result_due ? ST_MUL : ST_IDLE;
      end
      ST_MUL: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.result) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

>>> src/mart_dp.sv
// ----------------------------------------------------------------------------
// mart_dp: datapath of the moving average band threshold
// Configuration registers, sample ring memory, running sum, the two
// multipliers and the cross-multiplied band compare with the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mart_dp
  import mart_pkg::*;
#(
  parameter int unsigned MAX_WINDOW  = MART_MAX_WINDOW,
  parameter int unsigned SAMPLE_BITS = MART_SAMPLE_BITS
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [CFG_DAT_W-1:0]   cfg_data_i,
  input  wire logic [SAMPLE_BITS-1:0] sample_i,
  input  wire ctl_cmd_t               cmd_i,
  output ctl_status_t                 status_o,
  output logic [DEC_W-1:0]            decision_o,
  output logic [SUM_OUT_W-1:0]        window_sum_o
);

  localparam int unsigned PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned SUM_W = SAMPLE_BITS + WW_W;
  localparam int unsigned P_W   = SUM_W + TOL_W;
  localparam int unsigned CMP_W = SUM_W + FRAC_W + 1;

  logic [WW_W-1:0]        width_q;
  logic [TOL_W-1:0]       tol_q;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [WW_W-1:0]        fill_q, fill_d;
  logic [PTR_W-1:0]       wp_q, wp_d;
  logic [WW_W-1:0]        w_eff;
  logic [PTR_W-1:0]       slot_d, slot_q;
  logic [SAMPLE_BITS-1:0] newest_q;
  logic [SAMPLE_BITS-1:0] ring_mem [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] rd_data_q;
  logic [SUM_W-1:0]       nw_q;
  logic [P_W-1:0]         p_q;
  logic                   window_full;
  logic                   width_wr;
  logic [CMP_W-1:0]       base, upper, lower, lhs;
  decision_e              dec_d;
  logic [DEC_W-1:0]       dec_q;
  logic [SUM_W+SUM_OUT_W-1:0] sum_ext;
  logic [SUM_OUT_W-1:0]   sum_out_q;

  // Width clamped to 1..MAX_WINDOW.
  always_comb begin
    w_eff = width_q;
    if (width_q == '0) begin
      w_eff = WW_W'(1);
    end else if (32'(width_q) > 32'(MAX_WINDOW)) begin
      w_eff = WW_W'(MAX_WINDOW);
    end
  end

  assign slot_d      = (32'(wp_q) >= 32'(w_eff)) ? '0 : wp_q;
  assign window_full = (fill_q >= w_eff);
  assign status_o.result_due = window_full | ((fill_q + WW_W'(1)) >= w_eff);
  assign width_wr    = cfg_we_i & (cfg_idx_i == REG_WINDOW_WIDTH);

  always_comb begin
    sum_d  = sum_q;
    fill_d = fill_q;
    wp_d   = wp_q;
    if (width_wr) begin
      sum_d  = '0;
      fill_d = '0;
      wp_d   = '0;
    end else if (cmd_i.update) begin
      if (window_full) begin
        sum_d  = sum_q - SUM_W'(rd_data_q) + SUM_W'(newest_q);
        fill_d = w_eff;
      end else begin
        sum_d  = sum_q + SUM_W'(newest_q);
        fill_d = fill_q + WW_W'(1);
      end
      wp_d = ((32'(slot_q) + 32'd1) >= 32'(w_eff)) ? '0 : slot_q + PTR_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WINDOW_WIDTH_RST;
      tol_q   <= TOLERANCE_RST;
      sum_q   <= '0;
      fill_q  <= '0;
      wp_q    <= '0;
    end else begin
      if (width_wr) width_q <= cfg_data_i[WW_W-1:0];
      if (cfg_we_i && (cfg_idx_i == REG_TOLERANCE)) tol_q <= cfg_data_i[TOL_W-1:0];
      sum_q  <= sum_d;
      fill_q <= fill_d;
      wp_q   <= wp_d;
    end
  end

  // Sample ring: the old value of the slot is read as the sample is taken
  // and the new one written by the update command that follows.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rd_data_q <= ring_mem[slot_d];
    end
    if (cmd_i.update) begin
      ring_mem[slot_q] <= newest_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      newest_q <= sample_i;
      slot_q   <= slot_d;
    end
    if (cmd_i.update) begin
      nw_q <= SUM_W'(newest_q) * SUM_W'(w_eff);
    end
    if (cmd_i.mul) begin
      p_q <= P_W'(sum_q) * P_W'(tol_q);
    end
  end

  // newest*w*2^16 against sum*2^16 +/- sum*tol.
  assign base  = {1'b0, sum_q, FRAC_W'(0)};
  assign upper = base + CMP_W'(p_q);
  assign lower = base - CMP_W'(p_q);
  assign lhs   = {1'b0, nw_q, FRAC_W'(0)};

  always_comb begin
    dec_d = DEC_HOLD;
    if (sum_q != '0) begin
      if (lhs > upper) begin
        dec_d = DEC_SELL;
      end else if (lhs < lower) begin
        dec_d = DEC_BUY;
      end
    end
  end

  assign sum_ext = {SUM_OUT_W'(0), sum_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.result) begin
      dec_q     <= dec_d;
      sum_out_q <= sum_ext[SUM_OUT_W-1:0];
    end
  end

  assign decision_o   = dec_q;
  assign window_sum_o = sum_out_q;

endmodule

`default_nettype wire

>>> src/moving_average_ratio_threshold.sv
// A sample that gives a result passes through the READ, MUL and CMP states, and its result
// is registered on leaving CMP. A new sample is taken only in the idle state, after the
// ring read, sum update, tolerance multiply and compare of the last one (ring read and sum
// update while the window fills); a result waiting downstream holds the compare until taken.
// Reset: asynchronous, active low; clears the window (sum, fill count, pointer)
// and loads window_width 5 and tolerance 3277. Ring contents are not cleared.
// ----------------------------------------------------------------------------
// moving_average_ratio_threshold: moving average band threshold
// Keeps the last window_width Q16.16 samples and their sum. Once the window is
// full, each sample gives one result: sell when it lies above the mean scaled
// by (1 + tolerance), buy when below the mean scaled by (1 - tolerance), hold
// otherwise or when the window sum is zero, together with the window sum.
// ----------------------------------------------------------------------------
`default_nettype none

module moving_average_ratio_threshold
  import mart_pkg::*;
#(
  parameter int unsigned MAX_WINDOW  = MART_MAX_WINDOW,
  parameter int unsigned SAMPLE_BITS = MART_SAMPLE_BITS
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // Configuration write port. Index 0 is window_width, index 1 is tolerance.
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [CFG_DAT_W-1:0]   cfg_data_i,
  // Sample input channel.
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [SAMPLE_BITS-1:0] sample_i,
  // Result output channel.
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [DEC_W-1:0]            decision_o,
  output logic [SUM_OUT_W-1:0]        window_sum_o
);

  // The controller only sequences; all arithmetic and storage sit in the
  // datapath. The output register in the datapath lets a new sample be
  // transferred in while the previous result still waits downstream; the
  // controller holds in its compare state only if that result is still there.
  ctl_cmd_t    cmd;
  ctl_status_t status;

  mart_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Writing window_width empties the window so it refills from scratch;
  // a new tolerance applies from the next result with the window kept.
  mart_dp #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .sample_i     (sample_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .decision_o   (decision_o),
    .window_sum_o (window_sum_o)
  );

endmodule

`default_nettype wire

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of the moving average band threshold
// Streams Q16.16 price samples into the block through its valid/ready input
// and predicts every result from an internal copy of the window, sum and
// registers. Results are taken with random back-pressure and compared field
// by field. Registers are rewritten between bursts while the block is idle.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mart_pkg::*;

  localparam int unsigned IDLE_MAX       = 17;   // longest gap drawn on either side
  localparam int unsigned RANDOM_ITEMS   = 600;  // size of the random part
  localparam int unsigned SETTLE_CYCLES  = 6;    // block latency plus margin
  localparam int unsigned WATCHDOG_LIMIT = 2000; // cycles without any transfer or register write

  // One expected result of the block.
  typedef struct {
    decision_e                decision;
    logic [SUM_OUT_W-1:0]     window_sum;
  } band_result_t;

  // Clock, reset and all inputs of the block start at known values.
  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_idx_i   = '0;
  logic [CFG_DAT_W-1:0]        cfg_data_i  = '0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_ready_o;
  logic [MART_SAMPLE_BITS-1:0] sample_i    = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic [DEC_W-1:0]            decision_o;
  logic [SUM_OUT_W-1:0]        window_sum_o;

  // Samples waiting to be offered, and results waiting to arrive.
  logic [MART_SAMPLE_BITS-1:0] pending_prices[$];
  band_result_t                due_results[$];

  // When set, neither side inserts idle cycles, giving back-to-back stretches.
  logic        idle_off = 1'b0;
  int unsigned send_wait = 0;
  int unsigned recv_wait = 0;
  int unsigned quiet_cycles = 0;
  int unsigned bad_results = 0;

  // Predicted state of the block: the sample ring, its running sum, how many
  // entries are valid, where the next sample goes, and the two registers.
  logic [MART_SAMPLE_BITS-1:0] avg_ring[MART_MAX_WINDOW];
  logic [SUM_OUT_W-1:0]        avg_sum  = '0;
  int unsigned                 avg_fill = 0;
  int unsigned                 avg_wptr = 0;
  logic [WW_W-1:0]             reg_width = WINDOW_WIDTH_RST;
  logic [TOL_W-1:0]            reg_tol   = TOLERANCE_RST;

  moving_average_ratio_threshold DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_i     (sample_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .decision_o   (decision_o),
    .window_sum_o (window_sum_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Number of idle cycles before the next transfer on either side.
  function automatic int unsigned draw_wait();
    return idle_off ? 0 : $urandom_range(0, IDLE_MAX);
  endfunction

  // Appends a sample to the ones waiting to be offered.
  function automatic void queue_price(logic [MART_SAMPLE_BITS-1:0] price);
    pending_prices = {pending_prices, price};
  endfunction

  // Appends a predicted result to the ones waiting to arrive.
  function automatic void queue_result(band_result_t res);
    due_results = {due_results, res};
  endfunction

  // Pushes one sample through the predicted window. A width of zero behaves
  // as one and anything above the ring depth behaves as the full ring. Once
  // the window is full, the newest sample is compared with the mean scaled by
  // (1 +/- tolerance); both sides are multiplied out so no division is needed.
  function automatic void advance_window(logic [MART_SAMPLE_BITS-1:0] price);
    int unsigned w;
    int unsigned slot;
    logic [63:0] lhs, upper, lower;
    band_result_t res;
    w = (reg_width == 0) ? 1 : (reg_width > MART_MAX_WINDOW) ? MART_MAX_WINDOW : reg_width;
    if (avg_wptr >= w) avg_wptr = 0;
    slot = avg_wptr;
    if (avg_fill >= w) begin
      avg_sum  = avg_sum - SUM_OUT_W'(avg_ring[slot]);
      avg_fill = w;
    end else begin
      avg_fill++;
    end
    avg_ring[slot] = price;
    avg_sum  = avg_sum + SUM_OUT_W'(price);
    avg_wptr = (slot + 1 >= w) ? 0 : slot + 1;
    if (avg_fill < w) return;

    res.decision   = DEC_HOLD;
    res.window_sum = avg_sum;
    // A zero sum always holds, whatever the newest sample.
    if (avg_sum != 0) begin
      lhs   = (64'(price) * 64'(w)) << FRAC_W;
      upper = 64'(avg_sum) * (64'd1 << FRAC_W) + 64'(avg_sum) * 64'(reg_tol);
      lower = 64'(avg_sum) * ((64'd1 << FRAC_W) - 64'(reg_tol));
      if (lhs > upper) res.decision = DEC_SELL;
      else if (lhs < lower) res.decision = DEC_BUY;
    end
    queue_result(res);
  endfunction

  // Random price: mostly close to a base level so that all three decisions
  // show up, with some full-range, zero, all-ones and tiny values mixed in.
  function automatic logic [MART_SAMPLE_BITS-1:0] draw_price(logic [31:0] base);
    logic [63:0] span, v;
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return '0;
      2: return '1;
      3: return $urandom_range(0, 255);
      default: begin
        span = 64'(base) >> $urandom_range(2, 9);
        v = 64'(base) - span + 64'($urandom_range(0, 32'(2 * span)));
        if (v > 64'hFFFF_FFFF) return '1;
        return v[31:0];
      end
    endcase
  endfunction

  // Register write, one cycle wide. The predicted registers follow at once,
  // which is safe because writes only happen while the block is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DAT_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      REG_WINDOW_WIDTH: begin
        // A new width starts an empty window.
        reg_width = data[WW_W-1:0];
        avg_sum   = '0;
        avg_fill  = 0;
        avg_wptr  = 0;
      end
      REG_TOLERANCE: begin
        reg_tol = data[TOL_W-1:0];
      end
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Holds the sender until every queued sample is in and every predicted
  // result is out, then lets a sample that makes no result finish inside.
  // The check runs on falling edges, when the transfers of the rising edge
  // have settled.
  task automatic wait_window_idle();
    while (pending_prices.size() != 0 || in_valid_i || due_results.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Sender. A sample is predicted at the edge where it transfers; the gap
  // before the next one is drawn right then, so a zero gap keeps valid high.
  always @(posedge clk_i or negedge rst_ni) begin : price_sender
    int unsigned gap;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      sample_i   <= '0;
      send_wait  <= 0;
    end else if (!in_valid_i || in_ready_o) begin
      gap = send_wait;
      if (in_valid_i) begin
        advance_window(sample_i);
        gap = draw_wait();
      end
      if (gap == 0 && pending_prices.size() != 0) begin
        in_valid_i <= 1'b1;
        sample_i   <= pending_prices.pop_front();
      end else begin
        in_valid_i <= 1'b0;
        send_wait  <= (gap == 0) ? 0 : gap - 1;
      end
    end
  end

  // Receiver. After each result transfer, ready drops for a drawn number of
  // cycles, independent of whether the next result is already offered.
  always @(posedge clk_i or negedge rst_ni) begin : band_checker
    int unsigned gap;
    band_result_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_wait   <= 0;
    end else if (out_valid_o && out_ready_i) begin
      if (due_results.size() == 0) begin
        $error("unexpected result: decision %0d, window_sum 0x%0h", decision_o, window_sum_o);
        bad_results++;
      end else begin
        want = due_results.pop_front();
        if (decision_o !== want.decision) begin
          $error("decision: expected %0d, actual %0d", want.decision, decision_o);
          bad_results++;
        end
        if (window_sum_o !== want.window_sum) begin
          $error("window_sum: expected 0x%0h, actual 0x%0h", want.window_sum, window_sum_o);
          bad_results++;
        end
      end
      gap = draw_wait();
      if (gap == 0) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b0;
        recv_wait   <= gap - 1;
      end
    end else if (!out_ready_i) begin
      if (recv_wait == 0) out_ready_i <= 1'b1;
      else recv_wait <= recv_wait - 1;
    end
  end

  // Watchdog: a long stretch without any transfer means the block hung.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned sent, n, w_eff;
    logic [31:0] base;
    logic [WW_W-1:0] wsel;
    logic [CFG_DAT_W-1:0] wdata;
    logic [TOL_W-1:0] tsel;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset values: width 5. Five zero samples give a zero sum, which holds.
    // All-ones then lies far above the mean (sell), and a zero after it far
    // below (buy).
    repeat (5) queue_price('0);
    queue_price('1);
    queue_price('0);
    wait_window_idle();

    // A new tolerance keeps the window: the extremes of the band at once.
    write_reg(REG_TOLERANCE, '0);
    queue_price(32'h3333_3333);
    wait_window_idle();
    write_reg(REG_TOLERANCE, '1);
    queue_price(32'h0001_0000);
    wait_window_idle();

    // Width zero acts as one: every sample is its own window.
    write_reg(REG_WINDOW_WIDTH, 16'hFFE0);
    queue_price('1);
    queue_price(32'h0001_0000);
    wait_window_idle();

    // Width 31 acts as the full ring; all-ones everywhere gives the largest
    // sum, and with no tolerance the newest equals the mean exactly.
    write_reg(REG_WINDOW_WIDTH, 16'd31);
    write_reg(REG_TOLERANCE, '0);
    repeat (MART_MAX_WINDOW) queue_price('1);
    wait_window_idle();

    // Random bursts. Each burst runs under one setting and ends with the
    // sender held back until the block has drained.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      idle_off <= ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 7))
          0: wsel = '0;
          1: wsel = WW_W'(MART_MAX_WINDOW);
          2: wsel = WW_W'(1);
          3: wsel = WW_W'($urandom_range(MART_MAX_WINDOW + 1, 31));
          default: wsel = WW_W'($urandom_range(2, MART_MAX_WINDOW - 1));
        endcase
        // Bits above the width field are random and must be dropped.
        wdata = CFG_DAT_W'($urandom);
        wdata[WW_W-1:0] = wsel;
        write_reg(REG_WINDOW_WIDTH, wdata);
      end
      case ($urandom_range(0, 5))
        0: tsel = '0;
        1: tsel = '1;
        2: tsel = TOL_W'($urandom);
        default: tsel = TOL_W'($urandom_range(0, 8000));
      endcase
      write_reg(REG_TOLERANCE, tsel);

      w_eff = (reg_width == 0) ? 1 :
              (reg_width > MART_MAX_WINDOW) ? MART_MAX_WINDOW : reg_width;
      n = w_eff + $urandom_range(5, 50);
      base = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32'hFFFF) : $urandom;
      repeat (n) queue_price(draw_price(base));
      sent += n;
      wait_window_idle();
    end

    repeat (10) @(posedge clk_i);
    if (bad_results == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
